[hw/rtl/toc_pkg.sv]
package toc_pkg;

    localparam int WINDOW_DEPTH = 10;
    localparam logic [15:0] SHAPE_RATIO_REF = 16'd4096;

    localparam int SCORE_W    = 16;
    localparam int RATIO_W    = 16;
    localparam int RATIO_FRAC = 12;
    localparam int CONF_W     = 20;

    localparam int SUM_W     = $clog2(WINDOW_DEPTH * 65535 + 1);
    localparam int HEAD_W    = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
    localparam int FILL_W    = $clog2(WINDOW_DEPTH + 1);
    localparam int DIV_PRE   = RATIO_W - RATIO_FRAC;
    localparam int DIV_CNT_W = $clog2(RATIO_W);

    localparam logic [RATIO_W-1:0] RATIO_ONE = RATIO_W'(1 << RATIO_FRAC);

    // Confidence sums are kept in units of 2^-15/10 and scaled by 1/80 into Q7.12.
    // The 1/80 is a shift by four followed by a reciprocal multiply for 1/5.
    localparam int ACC_W      = 26;
    localparam int ACC_SHIFT  = 4;
    localparam int RECIP_IN_W = ACC_W - ACC_SHIFT;
    localparam int RECIP_K    = 25;
    localparam int RECIP_W    = 23;
    localparam int PROD_W     = RECIP_IN_W + RECIP_W;
    localparam logic [RECIP_W-1:0] RECIP_FIVE = RECIP_W'((1 << RECIP_K) / 5 + 1);
    localparam int Q_BIAS = 131072;
    localparam logic [ACC_W-1:0] ACC_OFFSET = ACC_W'(40 + 80 * Q_BIAS);

    localparam int W_OCC_RATIO = 56;
    localparam int W_OCC_IOU   = 5;
    localparam int W_OCC_SHAPE = 40;
    localparam int W_REA_SCORE = 20;
    localparam int W_REA_RATIO = 160;
    localparam int W_REA_SHAPE = 16;

    localparam logic signed [CONF_W:0] CONF_HI = (CONF_W+1)'((1 << (CONF_W - 1)) - 1);
    localparam logic signed [CONF_W:0] CONF_LO = -((CONF_W+1)'(1 << (CONF_W - 1)));

    localparam int PADDR_W = 5;
    localparam int PDATA_W = 32;

    typedef enum logic [2:0] {
        REG_OCC_SCORE_LIMIT = 3'd0,
        REG_OCC_RATIO_LIMIT = 3'd1,
        REG_OCC_IOU_LIMIT   = 3'd2,
        REG_REA_SCORE_LIMIT = 3'd3,
        REG_REA_RATIO_LIMIT = 3'd4,
        REG_REA_IOU_LIMIT   = 3'd5,
        REG_OCC_LEVEL       = 3'd6,
        REG_REA_LEVEL       = 3'd7
    } t_reg_idx;

    localparam logic [15:0] RST_OCC_SCORE_LIMIT = 16'd9830;
    localparam logic [15:0] RST_OCC_RATIO_LIMIT = 16'd2048;
    localparam logic [15:0] RST_OCC_IOU_LIMIT   = 16'd9830;
    localparam logic [15:0] RST_REA_SCORE_LIMIT = 16'd16384;
    localparam logic [15:0] RST_REA_RATIO_LIMIT = 16'd3277;
    localparam logic [15:0] RST_REA_IOU_LIMIT   = 16'd13107;
    localparam logic signed [CONF_W-1:0] RST_OCC_LEVEL = 20'sd4096;
    localparam logic signed [CONF_W-1:0] RST_REA_LEVEL = 20'sd4096;

    typedef struct packed {
        logic [15:0] track_score;
        logic [15:0] overlap_iou;
        logic [15:0] shape_ratio;
        logic        restart;
    } t_in;

    typedef struct packed {
        logic [15:0]              score_ratio_out;
        logic signed [CONF_W-1:0] occlusion_confidence;
        logic signed [CONF_W-1:0] reappear_confidence;
        logic                     occluded_flag;
        logic                     is_reappeared;
    } t_out;

    typedef struct packed {
        logic [15:0]              occluded_score_limit;
        logic [15:0]              occluded_ratio_limit;
        logic [15:0]              occluded_iou_limit;
        logic [15:0]              reappear_score_limit;
        logic [15:0]              reappear_ratio_limit;
        logic [15:0]              reappear_iou_limit;
        logic signed [CONF_W-1:0] occlusion_decision_level;
        logic signed [CONF_W-1:0] reappear_decision_level;
    } t_cfg;

    typedef struct packed {
        logic capture;
        logic append;
        logic quick;
        logic div_init;
        logic div_step;
        logic commit;
        logic conf_sum;
        logic conf_mul;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic full;
        logic quick_case;
    } t_sts;

    typedef enum logic [2:0] {
        S_IDLE     = 3'd0,
        S_START    = 3'd1,
        S_DIV      = 3'd2,
        S_UPDATE   = 3'd3,
        S_CONF_SUM = 3'd4,
        S_CONF_MUL = 3'd5,
        S_CONF_FIN = 3'd6
    } t_state;

    // Takes the reciprocal product, removes the bias and clamps to signed Q7.12.
    function automatic logic signed [CONF_W-1:0] conf_finish(input logic [PROD_W-1:0] p);
        logic [CONF_W-1:0]        q5;
        logic signed [CONF_W:0]   qs;
        logic signed [CONF_W-1:0] r;
        q5 = p[RECIP_K +: CONF_W];
        qs = $signed({1'b0, q5}) - $signed((CONF_W+1)'(Q_BIAS));
        if (qs > CONF_HI) begin
            r = CONF_HI[CONF_W-1:0];
        end else if (qs < CONF_LO) begin
            r = CONF_LO[CONF_W-1:0];
        end else begin
            r = qs[CONF_W-1:0];
        end
        return r;
    endfunction

endpackage

[hw/rtl/toc_regs.sv]
module toc_regs (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [toc_pkg::PADDR_W-1:0]  paddr,
    input  logic [toc_pkg::PDATA_W-1:0]  pwdata,
    output logic [toc_pkg::PDATA_W-1:0]  prdata,
    output logic                         pready,
    output toc_pkg::t_cfg                o_cfg
);
    import toc_pkg::*;

    t_cfg     r_cfg;
    t_reg_idx w_idx;
    logic     w_wr;

    assign pready = 1'b1;
    assign w_idx  = t_reg_idx'(paddr[PADDR_W-1:2]);
    assign w_wr   = psel && penable && pwrite;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.occluded_score_limit     <= RST_OCC_SCORE_LIMIT;
            r_cfg.occluded_ratio_limit     <= RST_OCC_RATIO_LIMIT;
            r_cfg.occluded_iou_limit       <= RST_OCC_IOU_LIMIT;
            r_cfg.reappear_score_limit     <= RST_REA_SCORE_LIMIT;
            r_cfg.reappear_ratio_limit     <= RST_REA_RATIO_LIMIT;
            r_cfg.reappear_iou_limit       <= RST_REA_IOU_LIMIT;
            r_cfg.occlusion_decision_level <= RST_OCC_LEVEL;
            r_cfg.reappear_decision_level  <= RST_REA_LEVEL;
        end else if (w_wr) begin
            unique case (w_idx)
                REG_OCC_SCORE_LIMIT: r_cfg.occluded_score_limit     <= pwdata[15:0];
                REG_OCC_RATIO_LIMIT: r_cfg.occluded_ratio_limit     <= pwdata[15:0];
                REG_OCC_IOU_LIMIT:   r_cfg.occluded_iou_limit       <= pwdata[15:0];
                REG_REA_SCORE_LIMIT: r_cfg.reappear_score_limit     <= pwdata[15:0];
                REG_REA_RATIO_LIMIT: r_cfg.reappear_ratio_limit     <= pwdata[15:0];
                REG_REA_IOU_LIMIT:   r_cfg.reappear_iou_limit       <= pwdata[15:0];
                REG_OCC_LEVEL:       r_cfg.occlusion_decision_level <= pwdata[CONF_W-1:0];
                REG_REA_LEVEL:       r_cfg.reappear_decision_level  <= pwdata[CONF_W-1:0];
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            REG_OCC_SCORE_LIMIT: prdata = PDATA_W'(r_cfg.occluded_score_limit);
            REG_OCC_RATIO_LIMIT: prdata = PDATA_W'(r_cfg.occluded_ratio_limit);
            REG_OCC_IOU_LIMIT:   prdata = PDATA_W'(r_cfg.occluded_iou_limit);
            REG_REA_SCORE_LIMIT: prdata = PDATA_W'(r_cfg.reappear_score_limit);
            REG_REA_RATIO_LIMIT: prdata = PDATA_W'(r_cfg.reappear_ratio_limit);
            REG_REA_IOU_LIMIT:   prdata = PDATA_W'(r_cfg.reappear_iou_limit);
            REG_OCC_LEVEL: prdata = PDATA_W'(unsigned'(r_cfg.occlusion_decision_level));
            REG_REA_LEVEL: prdata = PDATA_W'(unsigned'(r_cfg.reappear_decision_level));
        endcase
    end

endmodule

[hw/rtl/toc_ctrl.sv]
module toc_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    input  toc_pkg::t_sts i_sts,
    output toc_pkg::t_cmd o_cmd
);
    import toc_pkg::*;

    t_state               r_state, n_state;
    logic [DIV_CNT_W-1:0] r_cnt, n_cnt;
    logic                 r_out_valid, n_out_valid;
    logic                 w_out_free;

    assign w_out_free  = !r_out_valid || !i_out_stall;
    assign o_out_valid = r_out_valid;
    assign o_in_stall  = (r_state != S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        o_cmd       = '0;
        n_out_valid = r_out_valid && i_out_stall;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_START;
                end
            end
            S_START: begin
                if (!i_sts.full) begin
                    o_cmd.append = 1'b1;
                    n_state      = S_CONF_SUM;
                end else if (i_sts.quick_case) begin
                    o_cmd.quick = 1'b1;
                    n_state     = S_UPDATE;
                end else begin
                    o_cmd.div_init = 1'b1;
                    n_cnt          = '0;
                    n_state        = S_DIV;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                n_cnt          = r_cnt + 1'b1;
                if (r_cnt == DIV_CNT_W'(RATIO_W - 1)) begin
                    n_state = S_UPDATE;
                end
            end
            S_UPDATE: begin
                o_cmd.commit = 1'b1;
                n_state      = S_CONF_SUM;
            end
            S_CONF_SUM: begin
                o_cmd.conf_sum = 1'b1;
                n_state        = S_CONF_MUL;
            end
            S_CONF_MUL: begin
                o_cmd.conf_mul = 1'b1;
                n_state        = S_CONF_FIN;
            end
            S_CONF_FIN: begin
                if (w_out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

[hw/rtl/toc_dp.sv]
module toc_dp (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  toc_pkg::t_in  i_in_data,
    input  toc_pkg::t_cfg i_cfg,
    input  toc_pkg::t_cmd i_cmd,
    output toc_pkg::t_sts o_sts,
    output toc_pkg::t_out o_out_data
);
    import toc_pkg::*;

    t_in                   r_item;
    logic [SCORE_W-1:0]    r_win [WINDOW_DEPTH];
    logic [HEAD_W-1:0]     r_head;
    logic [FILL_W-1:0]     r_fill;
    logic [SUM_W-1:0]      r_sum;
    logic [RATIO_W-1:0]    r_ratio;
    logic [SUM_W-1:0]      r_rem;
    logic [RATIO_W-1:0]    r_dbits;
    logic [RATIO_W-1:0]    r_quot;
    logic [RECIP_IN_W-1:0] r_u_occ, r_u_rea;
    logic [PROD_W-1:0]     r_p_occ, r_p_rea;
    t_out                  r_out;

    logic [SUM_W-1:0]      w_prod;
    logic [SUM_W:0]        w_trial;
    logic                  w_fits;
    logic [HEAD_W-1:0]     w_head_next;
    logic                  w_win_wr;
    logic                  w_replace;
    logic [15:0]           w_d, w_sa, w_ra, w_ia, w_rs, w_rr;
    logic [16:0]           w_ri;
    logic [ACC_W-1:0]      w_occ_acc, w_rea_acc;
    logic signed [CONF_W-1:0] w_occ_q, w_rea_q;

    assign w_prod  = SUM_W'(r_item.track_score) * SUM_W'(WINDOW_DEPTH);
    assign w_trial = {r_rem, r_dbits[RATIO_W-1]};
    assign w_fits  = (w_trial >= {1'b0, r_sum});

    assign w_head_next = (r_head == HEAD_W'(WINDOW_DEPTH - 1)) ? '0 : r_head + 1'b1;
    assign w_replace   = (r_quot > i_cfg.occluded_ratio_limit);
    assign w_win_wr    = i_cmd.append || (i_cmd.commit && w_replace);

    assign o_sts.full       = (r_fill == FILL_W'(WINDOW_DEPTH));
    assign o_sts.quick_case = (r_sum == '0) ||
                              ({{DIV_PRE{1'b0}}, w_prod} >= {r_sum, {DIV_PRE{1'b0}}});

    always_ff @(posedge i_clk) begin
        if (w_win_wr) begin
            r_win[r_head] <= r_item.track_score;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_fill  <= '0;
            r_sum   <= '0;
            r_ratio <= RATIO_ONE;
        end else if (i_cmd.capture && i_in_data.restart) begin
            r_head  <= '0;
            r_fill  <= '0;
            r_sum   <= '0;
            r_ratio <= RATIO_ONE;
        end else if (i_cmd.append) begin
            r_head <= w_head_next;
            r_fill <= r_fill + 1'b1;
            r_sum  <= r_sum + SUM_W'(r_item.track_score);
        end else if (i_cmd.commit) begin
            r_ratio <= r_quot;
            if (w_replace) begin
                r_head <= w_head_next;
                r_sum  <= r_sum - SUM_W'(r_win[r_head]) + SUM_W'(r_item.track_score);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_item <= i_in_data;
        end
        if (i_cmd.quick) begin
            r_quot <= (r_sum == '0) ? '0 : '1;
        end else if (i_cmd.div_init) begin
            r_rem   <= w_prod >> DIV_PRE;
            r_dbits <= {w_prod[DIV_PRE-1:0], {RATIO_FRAC{1'b0}}};
        end else if (i_cmd.div_step) begin
            r_rem   <= w_fits ? SUM_W'(w_trial - {1'b0, r_sum}) : w_trial[SUM_W-1:0];
            r_dbits <= {r_dbits[RATIO_W-2:0], 1'b0};
            r_quot  <= {r_quot[RATIO_W-2:0], w_fits};
        end
        if (i_cmd.conf_sum) begin
            r_u_occ <= w_occ_acc[ACC_W-1:ACC_SHIFT];
            r_u_rea <= w_rea_acc[ACC_W-1:ACC_SHIFT];
        end
        if (i_cmd.conf_mul) begin
            r_p_occ <= PROD_W'(r_u_occ) * PROD_W'(RECIP_FIVE);
            r_p_rea <= PROD_W'(r_u_rea) * PROD_W'(RECIP_FIVE);
        end
        if (i_cmd.load_out) begin
            r_out.score_ratio_out      <= r_ratio;
            r_out.occlusion_confidence <= w_occ_q;
            r_out.reappear_confidence  <= w_rea_q;
            r_out.occluded_flag        <= (w_occ_q > i_cfg.occlusion_decision_level);
            r_out.is_reappeared        <= (w_rea_q > i_cfg.reappear_decision_level);
        end
    end

    always_comb begin
        w_d  = (r_item.shape_ratio >= SHAPE_RATIO_REF) ? r_item.shape_ratio - SHAPE_RATIO_REF
                                                       : SHAPE_RATIO_REF - r_item.shape_ratio;
        w_sa = (i_cfg.occluded_score_limit > r_item.track_score)
             ? i_cfg.occluded_score_limit - r_item.track_score : '0;
        w_ra = (i_cfg.occluded_ratio_limit > r_ratio) ? i_cfg.occluded_ratio_limit - r_ratio : '0;
        w_ia = (i_cfg.occluded_iou_limit > r_item.overlap_iou)
             ? i_cfg.occluded_iou_limit - r_item.overlap_iou : '0;
        w_rs = (r_item.track_score > i_cfg.reappear_score_limit)
             ? r_item.track_score - i_cfg.reappear_score_limit : '0;
        w_rr = (r_ratio > i_cfg.reappear_ratio_limit) ? r_ratio - i_cfg.reappear_ratio_limit : '0;
        w_ri = {1'b0, r_item.overlap_iou} - {1'b0, i_cfg.reappear_iou_limit};

        w_occ_acc = ACC_W'(w_sa)
                  + ACC_W'(w_ra) * ACC_W'(W_OCC_RATIO)
                  + ACC_W'(w_ia) * ACC_W'(W_OCC_IOU)
                  + ACC_W'(w_d)  * ACC_W'(W_OCC_SHAPE)
                  + ACC_OFFSET;
        w_rea_acc = ACC_W'(w_rs) * ACC_W'(W_REA_SCORE)
                  + ACC_W'(w_rr) * ACC_W'(W_REA_RATIO)
                  + {{(ACC_W-17){w_ri[16]}}, w_ri}
                  - ACC_W'(w_d)  * ACC_W'(W_REA_SHAPE)
                  + ACC_OFFSET;
    end

    assign w_occ_q    = conf_finish(r_p_occ);
    assign w_rea_q    = conf_finish(r_p_rea);
    assign o_out_data = r_out;

endmodule

[hw/rtl/track_occlusion_classifier.sv]
// Occlusion and reappearance classifier for one tracked object, one item per frame.
// The input channel carries the frame's score, IoU, shape ratio and restart bit; an
// item transfers when i_in_valid is high and o_in_stall is low. The output channel
// carries the score ratio, both confidences and both flags; a result transfers when
// o_out_valid is high and i_out_stall is low.
// Items are worked one at a time. While the score window fills, an item goes from
// capture through the append and the confidence sum, multiply and finish states, and
// the next item can transfer once the block is back in idle. Once the window is full,
// the score ratio comes from a radix-2 divider: setup, 16 quotient steps and the
// window update come before the confidence states. A zero or saturating ratio skips
// the divider but still passes through the window update state.
// The input is stalled while an item is at work. A finished result sits in the
// output register, so the next item is taken while the receiver stalls; the block
// then waits with its next result until the output register is free.
// The user writes thresholds and decision levels over the APB port only while the
// block is idle; the block does not enforce it. Reset restores register defaults,
// empties the window and sets the ratio to 1.0; a restart item first does both.
module track_occlusion_classifier (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  toc_pkg::t_in                i_in_data,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output toc_pkg::t_out               o_out_data,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [toc_pkg::PADDR_W-1:0] paddr,
    input  logic [toc_pkg::PDATA_W-1:0] pwdata,
    output logic [toc_pkg::PDATA_W-1:0] prdata,
    output logic                        pready
);
    import toc_pkg::*;

    t_cfg w_cfg;
    t_cmd w_cmd;
    t_sts w_sts;

    toc_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    toc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    toc_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_data  (i_in_data),
        .i_cfg      (w_cfg),
        .i_cmd      (w_cmd),
        .o_sts      (w_sts),
        .o_out_data (o_out_data)
    );

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input taken while an item is still at work");

    a_valid_from_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(w_cmd.load_out))
        else $error("result shown without an output load");

    a_load_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.load_out |-> (!o_out_valid || !i_out_stall))
        else $error("output register overwritten while its result is stalled");

    a_occ_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.occluded_flag ==
                         (o_out_data.occlusion_confidence > w_cfg.occlusion_decision_level)))
        else $error("occluded flag disagrees with its confidence");

endmodule

[dv/tb.sv]
module tb;
    import toc_pkg::*;

    class occlusion_scoreboard;
        t_cfg        cfg;
        logic [15:0] window [WINDOW_DEPTH];
        int          head;
        int          fill;
        longint      sum;
        longint      ratio;
        t_out        pending_verdicts [$];
        int          mismatches;
        int          compared;
        int          frames;
        int          restarts;
        int          saturated;
        int          zero_ratio;

        function new();
            cfg.occluded_score_limit     = RST_OCC_SCORE_LIMIT;
            cfg.occluded_ratio_limit     = RST_OCC_RATIO_LIMIT;
            cfg.occluded_iou_limit       = RST_OCC_IOU_LIMIT;
            cfg.reappear_score_limit     = RST_REA_SCORE_LIMIT;
            cfg.reappear_ratio_limit     = RST_REA_RATIO_LIMIT;
            cfg.reappear_iou_limit       = RST_REA_IOU_LIMIT;
            cfg.occlusion_decision_level = RST_OCC_LEVEL;
            cfg.reappear_decision_level  = RST_REA_LEVEL;
            mismatches = 0;
            compared   = 0;
            frames     = 0;
            restarts   = 0;
            saturated  = 0;
            zero_ratio = 0;
            clear_window();
        endfunction

        function void clear_window();
            foreach (window[i]) window[i] = '0;
            head  = 0;
            fill  = 0;
            sum   = 0;
            ratio = longint'(RATIO_ONE);
        endfunction

        function void set_reg(t_reg_idx idx, logic [31:0] v);
            case (idx)
                REG_OCC_SCORE_LIMIT: cfg.occluded_score_limit     = v[15:0];
                REG_OCC_RATIO_LIMIT: cfg.occluded_ratio_limit     = v[15:0];
                REG_OCC_IOU_LIMIT:   cfg.occluded_iou_limit       = v[15:0];
                REG_REA_SCORE_LIMIT: cfg.reappear_score_limit     = v[15:0];
                REG_REA_RATIO_LIMIT: cfg.reappear_ratio_limit     = v[15:0];
                REG_REA_IOU_LIMIT:   cfg.reappear_iou_limit       = v[15:0];
                REG_OCC_LEVEL:       cfg.occlusion_decision_level = v[19:0];
                REG_REA_LEVEL:       cfg.reappear_decision_level  = v[19:0];
                default: ;
            endcase
        endfunction

        static function longint excess(longint a, longint b);
            return (a > b) ? a - b : 0;
        endfunction

        // Scales a sum in units of 2^-15/10 into Q7.12, rounding half up, and clamps it.
        static function longint to_conf(longint x);
            longint y;
            longint q;
            y = x + 40;
            q = (y >= 0) ? y / 80 : -((-y + 79) / 80);
            if (q > 524287) q = 524287;
            if (q < -524288) q = -524288;
            return q;
        endfunction

        function void note_frame(t_in f);
            longint score;
            longint iou;
            longint d;
            longint occ;
            longint rea;
            longint occ_q;
            longint rea_q;
            t_out   e;
            frames++;
            score = longint'(f.track_score);
            iou   = longint'(f.overlap_iou);
            if (f.restart) begin
                restarts++;
                clear_window();
            end
            if (fill >= WINDOW_DEPTH) begin
                if (sum == 0) begin
                    ratio = 0;
                end else begin
                    ratio = score * WINDOW_DEPTH * (1 << RATIO_FRAC) / sum;
                    if (ratio > 65535) begin
                        ratio = 65535;
                        saturated++;
                    end
                end
                if (ratio == 0) zero_ratio++;
                if (ratio > longint'(cfg.occluded_ratio_limit)) begin
                    sum = sum - longint'(window[head]) + score;
                    window[head] = f.track_score;
                    head = (head + 1) % WINDOW_DEPTH;
                end
            end else begin
                window[head] = f.track_score;
                sum  = sum + score;
                head = (head + 1) % WINDOW_DEPTH;
                fill++;
            end
            d = longint'(f.shape_ratio) - longint'(SHAPE_RATIO_REF);
            if (d < 0) d = -d;
            occ = excess(longint'(cfg.occluded_score_limit), score)
                + W_OCC_RATIO * excess(longint'(cfg.occluded_ratio_limit), ratio)
                + W_OCC_IOU * excess(longint'(cfg.occluded_iou_limit), iou)
                + W_OCC_SHAPE * d;
            rea = W_REA_SCORE * excess(score, longint'(cfg.reappear_score_limit))
                + W_REA_RATIO * excess(ratio, longint'(cfg.reappear_ratio_limit))
                + (iou - longint'(cfg.reappear_iou_limit))
                - W_REA_SHAPE * d;
            occ_q = to_conf(occ);
            rea_q = to_conf(rea);
            e.score_ratio_out      = ratio[15:0];
            e.occlusion_confidence = occ_q[19:0];
            e.reappear_confidence  = rea_q[19:0];
            e.occluded_flag = occ_q > longint'($signed(cfg.occlusion_decision_level));
            e.is_reappeared = rea_q > longint'($signed(cfg.reappear_decision_level));
            pending_verdicts.insert(pending_verdicts.size(), e);
        endfunction

        function void check_verdict(t_out got);
            t_out e;
            bit   bad;
            if (pending_verdicts.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("unexpected result: ratio %0d occ %0d rea %0d flags %0b%0b",
                             got.score_ratio_out, got.occlusion_confidence,
                             got.reappear_confidence, got.occluded_flag, got.is_reappeared);
                end
                return;
            end
            e = pending_verdicts[0];
            pending_verdicts.delete(0);
            compared++;
            bad = (got.score_ratio_out !== e.score_ratio_out)
                || (got.occlusion_confidence !== e.occlusion_confidence)
                || (got.reappear_confidence !== e.reappear_confidence)
                || (got.occluded_flag !== e.occluded_flag)
                || (got.is_reappeared !== e.is_reappeared);
            if (bad) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("result %0d mismatch: ratio %0d/%0d occ %0d/%0d rea %0d/%0d",
                             compared, e.score_ratio_out, got.score_ratio_out,
                             e.occlusion_confidence, got.occlusion_confidence,
                             e.reappear_confidence, got.reappear_confidence);
                    $display("    occluded %0b/%0b reappeared %0b/%0b (expected/actual)",
                             e.occluded_flag, got.occluded_flag,
                             e.is_reappeared, got.is_reappeared);
                end
            end
        endfunction

        function int outstanding();
            return pending_verdicts.size();
        endfunction
    endclass

    logic               i_clk       = 1'b0;
    logic               i_rst_n     = 1'b0;
    logic               i_in_valid  = 1'b0;
    logic               o_in_stall;
    t_in                i_in_data   = '0;
    logic               o_out_valid;
    logic               i_out_stall = 1'b0;
    t_out               o_out_data;
    logic               psel        = 1'b0;
    logic               penable     = 1'b0;
    logic               pwrite      = 1'b0;
    logic [PADDR_W-1:0] paddr       = '0;
    logic [PDATA_W-1:0] pwdata      = '0;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    occlusion_scoreboard sb;

    int burst_left    = 0;
    int score_base    = 16384;
    int settings_seen = 0;
    int stall_mode    = 0;
    int mode_left     = 0;
    int run_left      = 0;
    bit stall_hold    = 1'b0;

    track_occlusion_classifier i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (mode_left == 0) begin
                stall_mode = $urandom_range(0, 2);
                mode_left  = $urandom_range(20, 200);
            end else begin
                mode_left--;
            end
            case (stall_mode)
                0: i_out_stall <= 1'b0;
                1: i_out_stall <= 1'($urandom_range(0, 1));
                default: begin
                    if (run_left == 0) begin
                        stall_hold = !stall_hold;
                        run_left   = $urandom_range(1, 25);
                    end else begin
                        run_left--;
                    end
                    i_out_stall <= stall_hold;
                end
            endcase
        end
    end

    always @(negedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            sb.check_verdict(o_out_data);
        end
    end

    function automatic t_in frame(int score, int iou, int shape, bit restart);
        t_in f;
        f.track_score = 16'(score);
        f.overlap_iou = 16'(iou);
        f.shape_ratio = 16'(shape);
        f.restart     = restart;
        return f;
    endfunction

    function automatic t_in next_frame();
        t_in f;
        int  pick;
        int  s;
        f.restart = ($urandom_range(0, 49) == 0);
        if (f.restart) begin
            case ($urandom_range(0, 3))
                0:       score_base = $urandom_range(0, 64);
                3:       score_base = $urandom_range(0, 65535);
                default: score_base = $urandom_range(1000, 32768);
            endcase
        end
        pick = $urandom_range(0, 99);
        if (pick < 50) begin
            s = score_base + int'($urandom_range(0, 4000)) - 2000;
            if (s < 0) s = 0;
            if (s > 65535) s = 65535;
            f.track_score = 16'(s);
        end else if (pick < 65) begin
            f.track_score = 16'($urandom);
        end else if (pick < 85) begin
            f.track_score = 16'($urandom_range(0, 32768));
        end else if (pick < 95) begin
            f.track_score = 16'($urandom_range(0, 64));
        end else begin
            f.track_score = '0;
        end
        f.overlap_iou = ($urandom_range(0, 4) == 0) ? 16'($urandom)
                                                     : 16'($urandom_range(0, 32768));
        pick = $urandom_range(0, 99);
        if (pick < 60) begin
            f.shape_ratio = 16'($urandom_range(2048, 6144));
        end else if (pick < 85) begin
            f.shape_ratio = 16'($urandom);
        end else begin
            f.shape_ratio = SHAPE_RATIO_REF;
        end
        return f;
    endfunction

    task automatic offer_frame(t_in f);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 30);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        i_in_valid <= 1'b1;
        i_in_data  <= f;
        do @(negedge i_clk); while (o_in_stall);
        sb.note_frame(f);
        @(posedge i_clk);
    endtask

    task automatic settle();
        i_in_valid <= 1'b0;
        burst_left = 0;
        while (sb.outstanding() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic apb_write(t_reg_idx idx, logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PADDR_W'(4 * int'(idx));
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(negedge i_clk); while (!pready);
        @(posedge i_clk);
        sb.set_reg(idx, value);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic write_settings(t_cfg c);
        settings_seen++;
        apb_write(REG_OCC_SCORE_LIMIT, {16'b0, c.occluded_score_limit});
        apb_write(REG_OCC_RATIO_LIMIT, {16'b0, c.occluded_ratio_limit});
        apb_write(REG_OCC_IOU_LIMIT,   {16'b0, c.occluded_iou_limit});
        apb_write(REG_REA_SCORE_LIMIT, {16'b0, c.reappear_score_limit});
        apb_write(REG_REA_RATIO_LIMIT, {16'b0, c.reappear_ratio_limit});
        apb_write(REG_REA_IOU_LIMIT,   {16'b0, c.reappear_iou_limit});
        apb_write(REG_OCC_LEVEL,       {12'b0, c.occlusion_decision_level});
        apb_write(REG_REA_LEVEL,       {12'b0, c.reappear_decision_level});
    endtask

    function automatic t_cfg pick_settings(int phase);
        t_cfg c;
        case (phase)
            0: begin
                c.occluded_score_limit     = 16'd0;
                c.occluded_ratio_limit     = 16'd0;
                c.occluded_iou_limit       = 16'd0;
                c.reappear_score_limit     = 16'd0;
                c.reappear_ratio_limit     = 16'd0;
                c.reappear_iou_limit       = 16'd0;
                c.occlusion_decision_level = 20'h80000;
                c.reappear_decision_level  = 20'h80000;
            end
            1: begin
                c.occluded_score_limit     = 16'd32768;
                c.occluded_ratio_limit     = 16'd65535;
                c.occluded_iou_limit       = 16'd32768;
                c.reappear_score_limit     = 16'd32768;
                c.reappear_ratio_limit     = 16'd65535;
                c.reappear_iou_limit       = 16'd32768;
                c.occlusion_decision_level = 20'h7FFFF;
                c.reappear_decision_level  = 20'h7FFFF;
            end
            5: begin
                c.occluded_score_limit     = RST_OCC_SCORE_LIMIT;
                c.occluded_ratio_limit     = RST_OCC_RATIO_LIMIT;
                c.occluded_iou_limit       = RST_OCC_IOU_LIMIT;
                c.reappear_score_limit     = RST_REA_SCORE_LIMIT;
                c.reappear_ratio_limit     = RST_REA_RATIO_LIMIT;
                c.reappear_iou_limit       = RST_REA_IOU_LIMIT;
                c.occlusion_decision_level = RST_OCC_LEVEL;
                c.reappear_decision_level  = RST_REA_LEVEL;
            end
            default: begin
                c.occluded_score_limit = 16'($urandom_range(0, 32768));
                c.occluded_ratio_limit = ($urandom_range(0, 3) == 0)
                                         ? 16'($urandom) : 16'($urandom_range(1024, 8192));
                c.occluded_iou_limit   = 16'($urandom_range(0, 32768));
                c.reappear_score_limit = 16'($urandom_range(0, 32768));
                c.reappear_ratio_limit = ($urandom_range(0, 3) == 0)
                                         ? 16'($urandom) : 16'($urandom_range(1024, 8192));
                c.reappear_iou_limit   = 16'($urandom_range(0, 32768));
                c.occlusion_decision_level = 20'(int'($urandom_range(0, 24576)) - 8192);
                c.reappear_decision_level  = 20'(int'($urandom_range(0, 24576)) - 8192);
            end
        endcase
        return c;
    endfunction

    initial begin
        #5000000;
        $display("TB_ERROR");
        $finish;
    end

    initial begin
        sb = new();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Window of zero scores: once full, the average is zero and the ratio drops to 0.
        offer_frame(frame(0, 0, 0, 1'b1));
        for (int i = 1; i < WINDOW_DEPTH; i++) begin
            offer_frame(frame(0, (i % 2) ? 65535 : 32768,
                              (i % 3 == 0) ? 4096 : ((i % 2) ? 65535 : 0), 1'b0));
        end
        offer_frame(frame(65535, 32768, 4096, 1'b0));
        offer_frame(frame(32768, 0, 65535, 1'b0));
        // Window of tiny scores: a large score saturates the ratio.
        offer_frame(frame(1, 13107, 4096, 1'b1));
        for (int i = 1; i < WINDOW_DEPTH; i++) begin
            offer_frame(frame(1, 9830, 4096 + i, 1'b0));
        end
        offer_frame(frame(65535, 32768, 4096, 1'b0));
        offer_frame(frame(32768, 20000, 3000, 1'b0));
        offer_frame(frame(0, 9830, 5000, 1'b0));
        settle();

        for (int phase = 0; phase < 6; phase++) begin
            write_settings(pick_settings(phase));
            for (int n = 0; n < 160; n++) begin
                offer_frame(next_frame());
            end
            settle();
        end
        repeat (40) @(posedge i_clk);

        $display("Sent %0d frames (%0d restarts) under %0d register settings.",
                 sb.frames, sb.restarts, settings_seen + 1);
        $display("Compared %0d results; ratio saturated %0d times, zero %0d times; %0d mismatches.",
                 sb.compared, sb.saturated, sb.zero_ratio, sb.mismatches);
        if (sb.mismatches == 0 && sb.outstanding() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

[files.f]
hw/rtl/toc_pkg.sv
hw/rtl/toc_regs.sv
hw/rtl/toc_ctrl.sv
hw/rtl/toc_dp.sv
hw/rtl/track_occlusion_classifier.sv
dv/tb.sv
